@@ src/spd_pkg.sv @@
// spd_pkg: shared constants and types of the signal pending/dispatch block.
// Command and result codes, fixed signal numbers, field widths.
// No dependencies.
`timescale 1ns / 1ps

package spd_pkg;

  localparam int MAX_SIGNAL_DEFAULT = 63;

  localparam int SIG_W  = 6;
  localparam int ADDR_W = 64;
  localparam int SET_W  = 64;
  localparam int RES_W  = 3;
  localparam int CODE_W = 7;

  typedef enum logic [2:0] {
    CMD_RAISE    = 3'd0,
    CMD_SET      = 3'd1,
    CMD_GET      = 3'd2,
    CMD_SWAP     = 3'd3,
    CMD_DISPATCH = 3'd4,
    CMD_RETURN   = 3'd5,
    CMD_CLEAR    = 3'd6
  } cmd_t;

  typedef enum logic [RES_W-1:0] {
    RES_NONE      = 3'd0,
    RES_HANDLED   = 3'd1,
    RES_BUSY      = 3'd2,
    RES_SUSPENDED = 3'd3,
    RES_KILLED    = 3'd4,
    RES_IGNORED   = 3'd5
  } res_t;

  // Linux numbering
  localparam logic [SIG_W-1:0] SIG_KILL = 6'd9;
  localparam logic [SIG_W-1:0] SIG_CHLD = 6'd17;
  localparam logic [SIG_W-1:0] SIG_CONT = 6'd18;
  localparam logic [SIG_W-1:0] SIG_STOP = 6'd19;
  localparam logic [SIG_W-1:0] SIG_URG  = 6'd23;

endpackage

@@ src/spd_req_if.sv @@
// spd_req_if: request channel (valid/ready) of the signal controller.
// Depends on spd_pkg.
`timescale 1ns / 1ps

interface spd_req_if;
  import spd_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [SIG_W-1:0]  signal_number;
  logic [ADDR_W-1:0] handler_address;
  logic [SET_W-1:0]  mask_value;

  modport source (output valid, command, signal_number, handler_address, mask_value,
                  input ready);
  modport sink   (input valid, command, signal_number, handler_address, mask_value,
                  output ready);
endinterface

@@ src/spd_rsp_if.sv @@
// spd_rsp_if: result channel (valid/ready) of the signal controller.
// Depends on spd_pkg.
`timescale 1ns / 1ps

interface spd_rsp_if;
  import spd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic [RES_W-1:0]         dispatch_result;
  logic signed [CODE_W-1:0] term_code;
  logic                     redirect;
  logic [ADDR_W-1:0]        handler_out;
  logic [SIG_W-1:0]         signal_out;
  logic [SET_W-1:0]         mask_out;

  modport source (output valid, accepted, dispatch_result, term_code, redirect,
                  handler_out, signal_out, mask_out, input ready);
  modport sink   (input valid, accepted, dispatch_result, term_code, redirect,
                  handler_out, signal_out, mask_out, output ready);
endinterface

@@ src/signal_pending_dispatch_top.sv @@
// signal_pending_dispatch_top: per-process signal controller.
// Depends on spd_pkg, spd_req_if, spd_rsp_if.
//
//   channel   dir   handshake      payload
//   request   in    valid/ready    command, signal_number, handler_address, mask_value
//   result    out   valid/ready    accepted, dispatch_result, term_code, redirect,
//                                  handler_out, signal_out, mask_out
//
// A new request is accepted only once the previous one has executed. The accept
// cycle picks the lowest unblocked pending signal and issues the action-table
// read; the execute stage then works on the read data and loads the result
// register once it is free. rst (synchronous) clears pending set, mask, mode and
// the table valid bits; no clearing pass. A result held by a stalled sink keeps
// one more request waiting in the execute stage; request.ready drops until it moves.
`timescale 1ns / 1ps

module signal_pending_dispatch_top #(
  parameter int MAX_SIGNAL = spd_pkg::MAX_SIGNAL_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  spd_req_if.sink   request,
  spd_rsp_if.source result
);
  import spd_pkg::*;

  localparam int NSIG  = MAX_SIGNAL + 1;
  localparam int IDX_W = $clog2(NSIG);
  localparam logic [SIG_W-1:0] SIG_LAST = SIG_W'(MAX_SIGNAL);

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_FROZEN = 2'd1,
    MODE_USER   = 2'd2
  } mode_t;

  // Architectural state
  logic [NSIG-1:0]  pending;
  logic [SET_W-1:0] blocking;
  mode_t            mode;
  logic [NSIG-1:0]  act_valid;

  // Action table: handler and action mask, one entry per signal
  logic [ADDR_W-1:0] handler_mem [NSIG];
  logic [SET_W-1:0]  mask_mem    [NSIG];
  logic [ADDR_W-1:0] rd_handler;
  logic [SET_W-1:0]  rd_mask;

  // Execute stage
  logic              exec_valid;
  logic [2:0]        cmd_q;
  logic [SIG_W-1:0]  sig_q;
  logic [ADDR_W-1:0] haddr_q;
  logic [SET_W-1:0]  mval_q;
  logic              win_any;
  logic [IDX_W-1:0]  win_idx;

  // Result register
  logic                     out_valid;
  logic                     out_acc;
  logic [RES_W-1:0]         out_res;
  logic signed [CODE_W-1:0] out_code;
  logic                     out_redir;
  logic [ADDR_W-1:0]        out_handler;
  logic [SIG_W-1:0]         out_sig;
  logic [SET_W-1:0]         out_mask;

  // Accept-stage logic
  logic             take;
  logic [NSIG-1:0]  ready_vec;
  logic             pick_any;
  logic [IDX_W-1:0] pick_idx;
  logic [IDX_W-1:0] rd_addr;

  // Execute-stage logic
  logic                     fire;
  logic                     sig_ok;
  logic                     settable;
  logic [IDX_W-1:0]         sig_idx;
  logic [SIG_W-1:0]         win_sig;
  logic                     acc_c;
  res_t                     res_c;
  logic signed [CODE_W-1:0] code_c;
  logic                     redir_c;
  logic [ADDR_W-1:0]        hout_c;
  logic [SIG_W-1:0]         sout_c;
  logic [SET_W-1:0]         mout_c;
  logic [NSIG-1:0]          pending_next;
  logic [SET_W-1:0]         blocking_next;
  mode_t                    mode_next;
  logic [NSIG-1:0]          act_valid_next;
  logic                     tbl_we;

  assign take           = request.valid && request.ready;
  assign request.ready  = !exec_valid;
  assign fire           = exec_valid && (!out_valid || result.ready);

  // Lowest unblocked pending signal; state is stable between accept and execute.
  assign ready_vec = pending & ~blocking[NSIG-1:0];

  always_comb begin
    pick_any = 1'b0;
    pick_idx = '0;
    for (int i = NSIG - 1; i >= 0; i--) begin
      if (ready_vec[i]) begin
        pick_any = 1'b1;
        pick_idx = IDX_W'(i);
      end
    end
  end

  assign rd_addr = (request.command == CMD_DISPATCH) ? pick_idx
                                                     : request.signal_number[IDX_W-1:0];

  // Table memory: read on accept, written by set action in the execute stage.
  // A write lands before the next request can be accepted, so no forwarding.
  always_ff @(posedge clk) begin
    if (take) begin
      rd_handler <= handler_mem[rd_addr];
      rd_mask    <= mask_mem[rd_addr];
    end
    if (tbl_we) begin
      handler_mem[sig_idx] <= haddr_q;
      mask_mem[sig_idx]    <= mval_q;
    end
  end

  assign sig_ok   = sig_q <= SIG_LAST;
  assign settable = sig_ok && (sig_q != SIG_KILL) && (sig_q != SIG_STOP);
  assign sig_idx  = sig_q[IDX_W-1:0];
  assign win_sig  = SIG_W'(win_idx);

  always_comb begin
    acc_c          = 1'b0;
    res_c          = RES_NONE;
    code_c         = '0;
    redir_c        = 1'b0;
    hout_c         = '0;
    sout_c         = '0;
    mout_c         = '0;
    pending_next   = pending;
    blocking_next  = blocking;
    mode_next      = mode;
    act_valid_next = act_valid;
    tbl_we         = 1'b0;

    case (cmd_q)
      CMD_RAISE: begin
        if (sig_ok) begin
          pending_next[sig_idx] = 1'b1;
          acc_c                 = 1'b1;
        end
      end
      CMD_SET: begin
        if (settable) begin
          tbl_we                  = fire;
          act_valid_next[sig_idx] = 1'b1;
          acc_c                   = 1'b1;
        end
      end
      CMD_GET: begin
        if (settable) begin
          if (act_valid[sig_idx]) begin
            hout_c = rd_handler;
            mout_c = rd_mask;
          end
          acc_c = 1'b1;
        end
      end
      CMD_SWAP: begin
        mout_c        = blocking;
        blocking_next = mval_q;
        acc_c         = 1'b1;
      end
      CMD_DISPATCH: begin
        acc_c = 1'b1;
        if (mode == MODE_FROZEN) begin
          // only an unblocked continue thaws
          if (pending[SIG_CONT] && !blocking[SIG_CONT]) begin
            pending_next[SIG_CONT] = 1'b0;
            mode_next              = MODE_NONE;
            res_c                  = RES_HANDLED;
          end else begin
            res_c = RES_SUSPENDED;
          end
        end else if (mode != MODE_NONE) begin
          res_c = RES_BUSY;
        end else if (win_any) begin
          pending_next[win_idx] = 1'b0;
          if (win_sig == SIG_KILL) begin
            res_c  = RES_KILLED;
            code_c = CODE_W'(-$signed({1'b0, win_sig}));
          end else if (win_sig == SIG_STOP) begin
            mode_next = MODE_FROZEN;
            res_c     = RES_SUSPENDED;
          end else if (act_valid[win_idx] && (rd_handler != '0)) begin
            mode_next = MODE_USER;
            res_c     = RES_HANDLED;
            redir_c   = 1'b1;
            hout_c    = rd_handler;
            sout_c    = win_sig;
          end else if ((win_sig == SIG_CHLD) || (win_sig == SIG_URG)) begin
            res_c = RES_IGNORED;
          end else begin
            res_c  = RES_KILLED;
            code_c = CODE_W'(-$signed({1'b0, win_sig}));
          end
        end
      end
      CMD_RETURN: begin
        if (mode == MODE_USER) begin
          mode_next = MODE_NONE;
          acc_c     = 1'b1;
        end
      end
      CMD_CLEAR: begin
        act_valid_next = '0;
        acc_c          = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      exec_valid <= 1'b0;
      out_valid  <= 1'b0;
      pending    <= '0;
      blocking   <= '0;
      mode       <= MODE_NONE;
      act_valid  <= '0;
    end else begin
      if (take) begin
        exec_valid <= 1'b1;
      end else if (fire) begin
        exec_valid <= 1'b0;
      end

      if (fire) begin
        out_valid <= 1'b1;
        pending   <= pending_next;
        blocking  <= blocking_next;
        mode      <= mode_next;
        act_valid <= act_valid_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q   <= request.command;
      sig_q   <= request.signal_number;
      haddr_q <= request.handler_address;
      mval_q  <= request.mask_value;
      win_any <= pick_any;
      win_idx <= pick_idx;
    end
    if (fire) begin
      out_acc     <= acc_c;
      out_res     <= res_c;
      out_code    <= code_c;
      out_redir   <= redir_c;
      out_handler <= hout_c;
      out_sig     <= sout_c;
      out_mask    <= mout_c;
    end
  end

  assign result.valid           = out_valid;
  assign result.accepted        = out_acc;
  assign result.dispatch_result = out_res;
  assign result.term_code       = out_code;
  assign result.redirect        = out_redir;
  assign result.handler_out     = out_handler;
  assign result.signal_out      = out_sig;
  assign result.mask_out        = out_mask;

endmodule
